// ===== src/dssf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dssf_pkg
// Shared types, constants and helpers for the decimal seven-segment frame
// encoder: digit limits, command and segment codes, sequencer states.
// ----------------------------------------------------------------------------
package dssf_pkg;

  localparam int MAX_DIGITS = 5;
  localparam int VAL_W      = 16;
  localparam int LEN_W      = 3;
  localparam int POS_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int BITCNT_W   = $clog2(VAL_W);

  localparam logic [BYTE_W-1:0] CMD_BASE  = 8'hC0;
  localparam logic [BYTE_W-1:0] COLON_BIT = 8'h80;
  localparam logic [LEN_W-1:0]  DIGIT_COUNT_RST = 3'd4;

  typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_CMD,
    S_DIGITS
  } state_t;

  // Converter status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dbl_status_t;

  // Common seven-segment pattern, bit0 = a ... bit6 = g
  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] digit);
    logic [BYTE_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Limit the requested digit count by the display size and the hard maximum
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] req,
                                                 input logic [LEN_W-1:0] dcnt);
    logic [LEN_W-1:0] n;
    n = req;
    if (n > dcnt) n = dcnt;
    if (n > LEN_W'(MAX_DIGITS)) n = LEN_W'(MAX_DIGITS);
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== src/dssf_dabble.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dssf_dabble
// Bit-serial binary to BCD converter: shifts the value in one bit per cycle
// and corrects each BCD digit by add-3 before every shift.
// ----------------------------------------------------------------------------
module dssf_dabble
  import dssf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] value,
  output      dbl_status_t      status,
  output      bcd_t             bcd
);

  logic [VAL_W-1:0]    bin_r, bin_nxt;
  bcd_t                bcd_r, bcd_nxt;
  bcd_t                adj;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  // Add 3 to every digit of 5 or more, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? 4'(bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = BITCNT_W'(VAL_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
      // Top digit never exceeds 6 for a 16-bit value, so its MSB drops out
      bcd_nxt = {adj[MAX_DIGITS-1][2:0], adj[MAX_DIGITS-2:0], bin_r[VAL_W-1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign bcd         = bcd_r;

`ifndef NO_ASSERTIONS
  // A new conversion never starts on top of a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("dssf_dabble: start while busy");

  // Finished result holds decimal digits only
  a_bcd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (bcd_r[0] < 4'd10) && (bcd_r[1] < 4'd10) && (bcd_r[2] < 4'd10)
               && (bcd_r[3] < 4'd10) && (bcd_r[4] < 4'd10))
    else $error("dssf_dabble: non-decimal digit");

  // Done follows the final shift
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("dssf_dabble: done without conversion");
`endif

endmodule
`default_nettype wire

// ===== src/decimal_seven_segment_frame_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_seven_segment_frame_encoder
// Turns a 16-bit value into a display frame: a command byte followed by one
// seven-segment byte per digit, most significant first.
// ----------------------------------------------------------------------------
// One request is taken at a time. After acceptance the value is converted to
// decimal by a bit-serial converter in 16 shift steps, then the command byte
// and the digit bytes leave one per cycle, unless the output stalls, through
// an output register. The next request is taken only once the final byte of
// the previous frame has been loaded into the output register; it may be
// taken while that final byte still waits.
module decimal_seven_segment_frame_encoder
  import dssf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [LEN_W-1:0]  cfg_data,
  // request channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [VAL_W-1:0]  in_value,
  input  wire logic [LEN_W-1:0]  in_length,
  input  wire logic              in_colon_on,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [BYTE_W-1:0] out_byte,
  output      logic              out_last
);

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  digit_count_r;
  logic [POS_W-1:0]  pos_r;
  logic [LEN_W-1:0]  len_r;
  logic              colon_r;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              out_free;
  logic              load_cmd;
  logic              load_dig;
  dbl_status_t       conv_status;
  bcd_t              bcd;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  dssf_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .value  (in_value),
    .status (conv_status),
    .bcd    (bcd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_CONV;
      S_CONV:   if (conv_status.done) state_nxt = S_CMD;
      S_CMD: begin
        if (out_free) state_nxt = (len_r == '0) ? S_IDLE : S_DIGITS;
      end
      S_DIGITS: if (out_free && cnt_r == '0) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Output register loads and digit counter
  always_comb begin
    load_cmd      = (state_r == S_CMD) && out_free;
    load_dig      = (state_r == S_DIGITS) && out_free;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load_cmd) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = CMD_BASE | BYTE_W'(pos_r);
      out_last_nxt  = (len_r == '0);
      cnt_nxt       = len_r - 1'b1;
    end else if (load_dig) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = seg_code(bcd[cnt_r]) | (colon_r ? COLON_BIT : '0);
      out_last_nxt  = (cnt_r == '0);
      cnt_nxt       = cnt_r - 1'b1;
    end
  end

  // Capture request fields; update digit counter, output byte and last flag
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r   <= in_position;
      len_r   <= clamp_len(in_length, digit_count_r);
      colon_r <= in_colon_on;
    end
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      digit_count_r <= DIGIT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) digit_count_r <= cfg_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  // A pending byte that is not the frame end means the frame is still open
  a_open_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r != S_IDLE))
    else $error("frame encoder: frame closed before last byte");

  // Digit index stays inside the clamped length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGITS) |-> (cnt_r < len_r))
    else $error("frame encoder: digit index out of range");

  // Bytes are only emitted once the conversion has finished
  a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMD || state_r == S_DIGITS) |-> !conv_status.busy)
    else $error("frame encoder: emitting during conversion");
`endif

endmodule
`default_nettype wire

// ===== tb/decimal_seven_segment_frame_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// decimal_seven_segment_frame_encoder_tb
// Checks every frame byte of the encoder against a predicted frame. Directed
// requests cover the digit extremes, the clamp and the zero-digit case. Random
// requests then run under several display sizes and idle/stall profiles.
// ----------------------------------------------------------------------------
module decimal_seven_segment_frame_encoder_tb;
  import dssf_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam int PHASE_ITEMS = 25;

  localparam logic [BYTE_W-1:0] SEG_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Predicts the bytes of each frame and matches them against the output
  class frame_book;
    typedef struct {
      logic [BYTE_W-1:0] seg;
      logic              last;
    } frame_byte_t;

    frame_byte_t       due_q[$];
    logic [LEN_W-1:0]  digit_count;
    int                errors;

    function new();
      digit_count = DIGIT_COUNT_RST;
      errors      = 0;
    endfunction

    function void set_digit_count(input logic [LEN_W-1:0] v);
      digit_count = v;
    endfunction

    // Expand one accepted request into its command byte and digit bytes
    function void note_request(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val,
                               input logic [LEN_W-1:0] len, input logic colon);
      int unsigned       n;
      int unsigned       span;
      int unsigned       rest;
      int unsigned       i;
      logic [BYTE_W-1:0] flag;
      frame_byte_t       entry;
      n = len;
      if (n > digit_count) n = digit_count;
      if (n > MAX_DIGITS) n = MAX_DIGITS;
      span = 1;
      for (i = 0; i < n; i++) span = span * 10;
      rest = val % span;
      flag = colon ? COLON_BIT : '0;
      entry.seg  = CMD_BASE | {2'b00, pos};
      entry.last = (n == 0);
      due_q.push_back(entry);
      // Emit digits from the most significant down
      for (i = 0; i < n; i++) begin
        span = span / 10;
        entry.seg  = SEG_TABLE[(rest / span) % 10] | flag;
        entry.last = (i + 1 == n);
        due_q.push_back(entry);
      end
    endfunction

    function void check_byte(input logic [BYTE_W-1:0] got_seg, input logic got_last);
      frame_byte_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, got_seg, got_last);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got_seg !== want.seg || got_last !== want.last) begin
        $display("%0t: frame byte mismatch: expected %h last %b, got %h last %b",
                 $time, want.seg, want.last, got_seg, got_last);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LEN_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [POS_W-1:0]  in_position;
  logic [VAL_W-1:0]  in_value;
  logic [LEN_W-1:0]  in_length;
  logic              in_colon_on;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  frame_book book;
  int        send_idle_pct;
  int        stall_pct;
  int        stuck_cycles;

  decimal_seven_segment_frame_encoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_position (in_position),
    .in_value    (in_value),
    .in_length   (in_length),
    .in_colon_on (in_colon_on),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  always #1 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check each accepted frame byte
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      book.check_byte(out_byte, out_last);
    end
  end

  // Count cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val,
                              input logic [LEN_W-1:0] len, input logic colon);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_position <= pos;
    in_value    <= val;
    in_length   <= len;
    in_colon_on <= colon;
    do @(posedge clk); while (in_stall !== 1'b0);
    book.note_request(pos, val, len, colon);
  endtask

  // Drop valid, then wait for every predicted byte and a quiet tail
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_digit_count(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    book.set_digit_count(v);
  endtask

  task automatic run_random(input int n_items);
    logic [VAL_W-1:0] val;
    repeat (n_items) begin
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        2:       val = VAL_W'($urandom_range(0, 99));
        3:       val = VAL_W'($urandom_range(9990, 10009));
        default: val = VAL_W'($urandom_range(0, 65535));
      endcase
      send_request(POS_W'($urandom_range(0, 63)), val, LEN_W'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin : main
    logic [LEN_W-1:0] sizes [8];
    int               idle_prof [4];
    int               stall_prof [4];
    int               p;
    sizes      = '{3'd5, 3'd1, 3'd4, 3'd7, 3'd6, 3'd0, 3'd2, 3'd3};
    idle_prof  = '{0, 70, 0, 27};
    stall_prof = '{0, 0, 70, 27};
    book          = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_position   = '0;
    in_value      = '0;
    in_length     = '0;
    in_colon_on   = 1'b0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    stuck_cycles  = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset display size of four: zero digits, extremes, padding, clamp
    send_request(6'd0,  16'd0,     3'd0, 1'b0);
    send_request(6'd63, 16'd65535, 3'd4, 1'b1);
    send_request(6'd5,  16'd1234,  3'd4, 1'b0);
    send_request(6'd17, 16'd12345, 3'd4, 1'b0);
    send_request(6'd42, 16'd7,     3'd3, 1'b1);
    send_request(6'd1,  16'd9876,  3'd7, 1'b0);
    send_request(6'd2,  16'd4321,  3'd6, 1'b1);
    drain();

    // Five digits at full width, all ten segment patterns
    write_digit_count(3'd5);
    send_request(6'd0,  16'd65535, 3'd5, 1'b0);
    send_request(6'd32, 16'd0,     3'd5, 1'b1);
    send_request(6'd9,  16'd12345, 3'd5, 1'b0);
    send_request(6'd10, 16'd60789, 3'd5, 1'b1);
    send_request(6'd11, 16'd42,    3'd7, 1'b0);
    drain();

    // Display size of zero yields the command byte alone
    write_digit_count(3'd0);
    send_request(6'd63, 16'd54321, 3'd5, 1'b1);
    send_request(6'd7,  16'd100,   3'd0, 1'b0);
    drain();

    // Display size above the hard maximum
    write_digit_count(3'd7);
    send_request(6'd20, 16'd54321, 3'd7, 1'b0);
    send_request(6'd21, 16'd99,    3'd6, 1'b1);
    drain();

    write_digit_count(3'd1);
    send_request(6'd3,  16'd65529, 3'd1, 1'b1);
    send_request(6'd4,  16'd8,     3'd2, 1'b0);
    drain();

    // Random requests across display sizes and idle/stall profiles
    for (p = 0; p < 8; p++) begin
      send_idle_pct = 0;
      stall_pct     = 0;
      write_digit_count(sizes[p]);
      send_idle_pct = idle_prof[p % 4];
      stall_pct     = stall_prof[p % 4];
      run_random(PHASE_ITEMS);
    end

    if (book.pending() != 0) begin
      $display("%0t: %0d frame bytes never arrived", $time, book.pending());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dssf_pkg.sv
src/dssf_dabble.sv
src/decimal_seven_segment_frame_encoder.sv
tb/decimal_seven_segment_frame_encoder_tb.sv
